### hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int OCC_W       = 5;

  // in_tdata:  item_data, item_priority
  localparam int IN_TDATA_W  = 64;
  // out_tdata: head_data, head_priority, occupancy, is_empty, is_full, pad
  localparam int OUT_TDATA_W = 72;

  // request kinds (in_tuser)
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  // result status codes (out_tuser)
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // apply it to the cell row and load the output register
  } spq_cmd_t;

endpackage

### hdl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: request handshake, execution sequencing, output valid.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted cell row with per-cell compare, shift on insert and remove, and
// the output register.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::spq_cmd_t                   cmd,
  input  logic                                req_func,
  input  logic [spq_pkg::WORD_W-1:0]          req_data,
  input  logic [spq_pkg::WORD_W-1:0]          req_prio,
  output logic [spq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [1:0]                          out_tuser
);
  import spq_pkg::*;

  logic              func_r;
  logic [WORD_W-1:0] rdata_r, rprio_r;

  logic [WORD_W-1:0] data_r [QUEUE_DEPTH];
  logic [WORD_W-1:0] prio_r [QUEUE_DEPTH];
  logic [WORD_W-1:0] data_nxt [QUEUE_DEPTH];
  logic [WORD_W-1:0] prio_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [QUEUE_DEPTH-1:0] keep;
  logic                   is_full, is_empty;
  logic [1:0]             status;
  logic [WORD_W-1:0]      head_data, head_prio;
  logic [CNT_W+OCC_W-1:0] cnt_ext;
  logic                   empty_nxt, full_nxt;

  logic [OUT_TDATA_W-1:0] tdata_r;
  logic [1:0]             tuser_r;

  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // a cell stays put when it is occupied and not below the new priority
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count_r) && !($signed(prio_r[i]) < $signed(rprio_r));
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      data_nxt[i] = data_r[i];
      prio_nxt[i] = prio_r[i];
    end
    count_nxt = count_r;
    status    = ST_OK;
    if (func_r == FN_INSERT) begin
      if (is_full) begin
        status = ST_FULL;
      end else begin
        if (!keep[0]) begin
          data_nxt[0] = rdata_r;
          prio_nxt[0] = rprio_r;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (!keep[i]) begin
            if (keep[i-1]) begin
              data_nxt[i] = rdata_r;
              prio_nxt[i] = rprio_r;
            end else begin
              data_nxt[i] = data_r[i-1];
              prio_nxt[i] = prio_r[i-1];
            end
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status = ST_EMPTY;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          data_nxt[i] = data_r[i+1];
          prio_nxt[i] = prio_r[i+1];
        end
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  assign empty_nxt = (count_nxt == '0);
  assign full_nxt  = (count_nxt == CNT_W'(QUEUE_DEPTH));
  assign head_data = empty_nxt ? '1 : data_nxt[0];
  assign head_prio = empty_nxt ? '1 : prio_nxt[0];
  assign cnt_ext   = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= req_func;
      rdata_r <= req_data;
      rprio_r <= req_prio;
    end
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        data_r[i] <= data_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
      tdata_r <= {1'b0, full_nxt, empty_nxt, cnt_ext[OCC_W-1:0], head_prio, head_data};
      tuser_r <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

endmodule

### hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted row of cells, served by
// descending priority, first come first served among equal priorities.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  -------  ---------  -------------------------------------------------------
//  in_      slave      one request: insert an item or remove the head entry
//  out_     master     one result per request: head entry, occupancy, status
//
//  Each request is first taken into the request register; then every cell
//  compares its priority with the new one and the row shifts.
//  A new request is taken while the previous result waits in the output
//  register; a stalled output holds the update until that register frees.
//  Reset clears the occupancy and the handshake state; cell contents are
//  not cleared, as only occupied cells are ever read.
//
module sorted_priority_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]  in_tdata,   // item_data[31:0], item_priority[63:32]
  input  logic                            in_tuser,   // func[0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata,  // head_data[31:0], head_priority[63:32],
                                                      // occupancy[68:64], is_empty[69],
                                                      // is_full[70], zero pad[71]
  output logic [1:0]                      out_tuser   // status[1:0]
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // sequence request acceptance, execution and result hand-off
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // hold the sorted entries and build each result
  spq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req_func  (in_tuser),
    .req_data  (in_tdata[WORD_W-1:0]),
    .req_prio  (in_tdata[2*WORD_W-1:WORD_W]),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### hdl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import spq_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // an empty queue reports no occupancy and all-ones head fields
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[69] |-> (out_tdata[68:64] == 5'd0) && (out_tdata[63:0] == '1))
    else $error("empty result with head or occupancy");

  // a refused insert reports a full queue that is not empty
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[70] && !out_tdata[69])
    else $error("insert refused without full queue");

  // a request taken this cycle is not followed by another the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken before execution");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
